@@ design/eps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_pkg
// shared types, constants and the series coefficient rom for the ellipse
// perimeter block
// ----------------------------------------------------------------------------
package eps_pkg;

  // default number of series terms
  localparam int unsigned MaxTermsDefault = 100;

  // coefficient rom covers term indices 0 to 127
  localparam int unsigned RomDepth = 128;
  localparam int unsigned CoefIdxW = 7;

  // restoring divider, one quotient bit per cycle
  localparam int unsigned DivSteps = 32;
  localparam int unsigned StepW    = 5;

  // wide product accumulator
  localparam int unsigned AccW = 128;

  // 1.0 in q1.32 and round(pi * 2^32)
  localparam logic [32:0] One    = 33'h1_0000_0000;
  localparam logic [33:0] PiQ32  = 34'h3_243F_6A89;

  typedef enum logic [1:0] {
    MopRr,    // r * r
    MopCh,    // coefficient * power of h
    MopHh,    // power of h * h
    MopWide   // one 32 x 32 limb of a wide product
  } mul_op_e;

  typedef logic [32:0] coef_rom_t [RomDepth];

  // command group from the controller
  typedef struct packed {
    logic                load_in;
    logic                clear;
    logic                init_div;
    logic                div_step;
    logic                r_one;
    logic                mul_issue;
    mul_op_e             mul_op;
    logic [CoefIdxW-1:0] coef_idx;
    logic [1:0]          limb;
    logic                take_h;
    logic                take_term;
    logic                take_hp;
    logic                w_load1;
    logic                w_load2;
    logic                w_acc;
    logic                res_load;
  } eps_cmd_t;

  // status group back to the controller
  typedef struct packed {
    logic s_zero;
    logic d_eq_s;
    logic term_zero;
  } eps_stat_t;

  // shift-subtract quotient, only evaluated while the rom is built
  function automatic logic [63:0] rom_quotient(input logic [63:0] num,
                                               input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // binomial(1/2, n)^2 built in q1.56, each entry kept as q1.32
  function automatic coef_rom_t coef_rom_build();
    coef_rom_t   rom;
    logic [63:0] c;
    logic [63:0] q;
    logic [63:0] m;
    c = 64'd1 << 56;
    for (int k = 0; k < RomDepth; k++) begin
      if (k > 0) begin
        m = 64'(2 * k);
        q = (k == 1) ? 64'd1 : 64'(2 * k - 3);
        c = rom_quotient(c * q, m);
        c = rom_quotient(c * q, m);
      end
      rom[k] = c[56:24];
    end
    return rom;
  endfunction

  localparam coef_rom_t CoefRom = coef_rom_build();

endpackage

@@ design/eps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_ctrl
// sequencer: division, series loop on the shared multiplier, final scaling
// ----------------------------------------------------------------------------
module eps_ctrl
  import eps_pkg::*;
#(
  parameter int unsigned MaxTerms = MaxTermsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  input  eps_stat_t stat_i,
  output eps_cmd_t  cmd_o
);

  localparam int unsigned TermCntW = $clog2(MaxTerms + 1);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StCheck  = 4'd1;
  localparam logic [3:0] StDiv    = 4'd2;
  localparam logic [3:0] StHMul   = 4'd3;
  localparam logic [3:0] StHTake  = 4'd4;
  localparam logic [3:0] StTMul   = 4'd5;
  localparam logic [3:0] StTAcc   = 4'd6;
  localparam logic [3:0] StHpTake = 4'd7;
  localparam logic [3:0] StFin    = 4'd8;
  localparam logic [3:0] StW1     = 4'd9;
  localparam logic [3:0] StWe1    = 4'd10;
  localparam logic [3:0] StWl2    = 4'd11;
  localparam logic [3:0] StW2     = 4'd12;
  localparam logic [3:0] StWe2    = 4'd13;
  localparam logic [3:0] StRes    = 4'd14;

  logic [3:0]          state_q, state_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [TermCntW-1:0] term_q, term_d;
  logic [TermCntW-1:0] term_inc;
  logic                out_valid_q, out_valid_d;

  assign term_inc = term_q + TermCntW'(1);

  always_comb begin
    cmd_o       = '0;
    cmd_o.mul_op = MopRr;
    in_ready_o  = 1'b0;
    state_d     = state_q;
    step_d      = step_q;
    term_d      = term_q;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StCheck;
        end
      end
      StCheck: begin
        if (stat_i.s_zero) begin
          cmd_o.clear = 1'b1;
          state_d     = StRes;
        end else if (stat_i.d_eq_s) begin
          cmd_o.r_one = 1'b1;
          state_d     = StHMul;
        end else begin
          cmd_o.init_div = 1'b1;
          step_d         = '0;
          state_d        = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + StepW'(1);
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = StHMul;
        end
      end
      StHMul: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.mul_op    = MopRr;
        state_d         = StHTake;
      end
      StHTake: begin
        cmd_o.take_h = 1'b1;
        term_d       = '0;
        state_d      = StTMul;
      end
      StTMul: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.mul_op    = MopCh;
        cmd_o.coef_idx  = CoefIdxW'(term_q);
        state_d         = StTAcc;
      end
      StTAcc: begin
        cmd_o.take_term = 1'b1;
        if (stat_i.term_zero) begin
          state_d = StFin;
        end else begin
          cmd_o.mul_issue = 1'b1;
          cmd_o.mul_op    = MopHh;
          state_d         = StHpTake;
        end
      end
      StHpTake: begin
        cmd_o.take_hp = 1'b1;
        term_d        = term_inc;
        if (term_inc == TermCntW'(MaxTerms)) begin
          state_d = StFin;
        end else begin
          // next term uses the power that lands this cycle
          cmd_o.mul_issue = 1'b1;
          cmd_o.mul_op    = MopCh;
          cmd_o.coef_idx  = CoefIdxW'(term_inc);
          state_d         = StTAcc;
        end
      end
      StFin: begin
        cmd_o.w_load1 = 1'b1;
        step_d        = '0;
        state_d       = StW1;
      end
      StW1, StW2: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.mul_op    = MopWide;
        cmd_o.limb      = step_q[1:0];
        cmd_o.w_acc     = (step_q != '0);
        step_d          = step_q + StepW'(1);
        if (step_q == StepW'(3)) begin
          state_d = (state_q == StW1) ? StWe1 : StWe2;
        end
      end
      StWe1: begin
        cmd_o.w_acc = 1'b1;
        state_d     = StWl2;
      end
      StWl2: begin
        cmd_o.w_load2 = 1'b1;
        step_d        = '0;
        state_d       = StW2;
      end
      StWe2: begin
        cmd_o.w_acc = 1'b1;
        state_d     = StRes;
      end
      StRes: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = cmd_o.res_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      term_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/eps_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_datapath
// radius sum and difference, divider, shared multiplier, series sum and
// wide product accumulator
// ----------------------------------------------------------------------------
module eps_datapath
  import eps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  eps_cmd_t    cmd_i,
  output eps_stat_t   stat_o,
  input  logic [31:0] minor_axis_i,
  input  logic [31:0] major_axis_i,
  output logic [34:0] perimeter_o
);

  logic [32:0]     s_q, rem_q, r_q;
  logic [31:0]     d_q;
  logic [32:0]     ratio_h_q, hp_q;
  logic [39:0]     series_sum_q;
  logic [63:0]     prod_q, wa_q, wb_q;
  logic [32:0]     spec_q;
  logic            spec_v_q;
  logic [1:0]      pp_sh_q;
  logic [AccW-1:0] acc_q;
  logic [34:0]     perimeter_q;

  logic [32:0]     x, y, mq, hp_next, spec;
  logic            spec_v;
  logic [63:0]     prod_d;
  logic [33:0]     rem_sh;
  logic            rem_ge;
  logic [AccW-1:0] pp_ext;

  // q0.32 product result, with the exact cases where a factor is 1.0
  assign mq      = spec_v_q ? spec_q : {1'b0, prod_q[63:32]};
  assign hp_next = cmd_i.take_hp ? mq : hp_q;

  always_comb begin
    case (cmd_i.mul_op)
      MopRr: begin
        x = r_q;
        y = r_q;
      end
      MopCh: begin
        x = CoefRom[cmd_i.coef_idx];
        y = hp_next;
      end
      MopHh: begin
        x = hp_q;
        y = ratio_h_q;
      end
      MopWide: begin
        x = {1'b0, cmd_i.limb[1] ? wa_q[63:32] : wa_q[31:0]};
        y = {1'b0, cmd_i.limb[0] ? wb_q[63:32] : wb_q[31:0]};
      end
      default: begin
        x = '0;
        y = '0;
      end
    endcase
  end

  assign spec_v = (cmd_i.mul_op != MopWide) && (x[32] || y[32]);
  assign spec   = x[32] ? ((y[32] && (y[31:0] != 32'd0)) ? One : y) : x;
  assign prod_d = {32'd0, x[31:0]} * {32'd0, y[31:0]};

  // restoring division step
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, s_q});

  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_ext = {64'd0, prod_q};
      2'd1:    pp_ext = {32'd0, prod_q, 32'd0};
      2'd2:    pp_ext = {prod_q, 64'd0};
      default: pp_ext = '0;
    endcase
  end

  assign stat_o.s_zero    = (s_q == 33'd0);
  assign stat_o.d_eq_s    = ({1'b0, d_q} == s_q);
  assign stat_o.term_zero = (mq == 33'd0);
  assign perimeter_o      = perimeter_q;

  // series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_h_q    <= '0;
      hp_q         <= '0;
      series_sum_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        ratio_h_q    <= '0;
        hp_q         <= '0;
        series_sum_q <= '0;
      end else if (cmd_i.take_h) begin
        ratio_h_q    <= mq;
        hp_q         <= One;
        series_sum_q <= '0;
      end else begin
        hp_q <= hp_next;
        if (cmd_i.take_term) begin
          series_sum_q <= series_sum_q + 40'(mq);
        end
      end
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      s_q <= {1'b0, minor_axis_i} + {1'b0, major_axis_i};
      d_q <= (major_axis_i > minor_axis_i) ? major_axis_i - minor_axis_i
                                           : minor_axis_i - major_axis_i;
    end
    if (cmd_i.init_div) begin
      rem_q <= {1'b0, d_q};
      r_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? 33'(rem_sh - {1'b0, s_q}) : rem_sh[32:0];
      r_q   <= {r_q[31:0], rem_ge};
    end else if (cmd_i.r_one) begin
      r_q <= One;
    end
    if (cmd_i.mul_issue) begin
      prod_q   <= prod_d;
      spec_q   <= spec;
      spec_v_q <= spec_v;
      pp_sh_q  <= {1'b0, cmd_i.limb[1]} + {1'b0, cmd_i.limb[0]};
    end
    if (cmd_i.w_load1) begin
      wa_q <= {31'd0, s_q};
      wb_q <= {24'd0, series_sum_q};
    end else if (cmd_i.w_load2) begin
      wa_q <= acc_q[79:16];
      wb_q <= {30'd0, PiQ32};
    end
    if (cmd_i.clear || cmd_i.w_load1 || cmd_i.w_load2) begin
      acc_q <= '0;
    end else if (cmd_i.w_acc) begin
      acc_q <= acc_q + pp_ext;
    end
    if (cmd_i.res_load) begin
      // saturate above 35 bits
      perimeter_q <= (|acc_q[111:83]) ? '1 : acc_q[82:48];
    end
  end

endmodule

@@ design/ellipse_perimeter_series_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_perimeter_series_top
// ellipse perimeter from two q16.16 semi-axes by the gauss-kummer series
// ----------------------------------------------------------------------------
// usage
//   slave side takes one request: minor and major semi-axis, unsigned q16.16
//   master side returns the perimeter, unsigned q19.16, one per request
//   one request is worked on at a time; s_axis_tready is high only when the
//   sequencer is idle
//   a request runs through the restoring divider for h, then the series
//   terms, at most MaxTerms of them, on the one shared 32 x 32 multiplier,
//   then the two limb-serial wide products
//   one radius zero skips the divider and sums all MaxTerms terms
//   both radii zero skips the divider and the series and gives 0
//   a finished result sits in the output register; the next request is
//   taken while it waits, and a stalled receiver holds back only the
//   following result
//   reset clears the sequencer, the output valid and the series state
// ----------------------------------------------------------------------------
module ellipse_perimeter_series_top
  import eps_pkg::*;
#(
  parameter int unsigned MaxTerms = MaxTermsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // minor_axis [31:0], major_axis [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // perimeter [34:0], zero fill [39:35]
);

  eps_cmd_t    cmd;
  eps_stat_t   stat;
  logic [34:0] perimeter;

  // sequencer
  eps_ctrl #(
    .MaxTerms(MaxTerms)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic and output register
  eps_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .minor_axis_i(s_axis_tdata[31:0]),
    .major_axis_i(s_axis_tdata[63:32]),
    .perimeter_o (perimeter)
  );

  assign m_axis_tdata = {5'd0, perimeter};

  // a multiplier result is consumed only in the cycle after it was issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take_h || cmd.take_term || cmd.take_hp) |-> $past(cmd.mul_issue))
    else $error("multiplier result taken without a product in flight");

  // the output register is never overwritten while a result is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  // both radii zero gives a zero perimeter on the short path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tdata == 64'd0) && !m_axis_tvalid)
      |-> ##3 (m_axis_tvalid && (m_axis_tdata == 40'd0)))
    else $error("zero radii did not give a zero perimeter");

endmodule
